### sv/sobg_pkg.sv
// shared constants and types for the 3x3 sobel gradient block
package sobg_pkg;

    // default geometry and sample format
    localparam int MAX_COLS_DEF   = 1024;
    localparam int SAMPLE_W_DEF   = 16;

    // fixed field widths
    localparam int ROW_W          = 16;
    localparam int CFG_COLS_W     = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;

    // reset frame size
    localparam logic [ROW_W-1:0] FRAME_ROWS_RST = 16'd1024;
    localparam int               FRAME_COLS_RST = 1024;

    // request function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // result queue depth, power of two
    localparam int RESQ_DEPTH = 8;

    // window update command
    typedef struct packed {
        logic push;
        logic first;
    } t_win_cmd;

    // per-request control carried down the pipeline
    typedef struct packed {
        logic     line_wr;
        t_win_cmd win;
        logic     top_sel_m;
        logic     bot_sel_m;
        logic     emit_prev;
        logic     emit_last;
        logic     frame_end;
    } t_item_ctl;

endpackage

### sv/sobg_lines.sv
// two line buffers with registered read and write-to-read forwarding
module sobg_lines #(
    parameter int MAX_COLS = sobg_pkg::MAX_COLS_DEF,
    parameter int SW       = sobg_pkg::SAMPLE_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_COLS)-1:0]   i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]   i_wr_addr,
    input  logic signed [SW-1:0]          i_wr_sample,
    output logic signed [SW-1:0]          o_above,
    output logic signed [SW-1:0]          o_two_above
);

    localparam int AW = $clog2(MAX_COLS);

    logic signed [SW-1:0] mem_above [MAX_COLS];
    logic signed [SW-1:0] mem_two   [MAX_COLS];

    logic signed [SW-1:0] r_rd_above;
    logic signed [SW-1:0] r_rd_two;
    logic                 r_fwd_hit;
    logic signed [SW-1:0] r_fwd_above;
    logic signed [SW-1:0] r_fwd_two;

    // synchronous read, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        r_rd_above <= mem_above[i_rd_addr];
        r_rd_two   <= mem_two[i_rd_addr];
    end

    // write back: the sample moves to the line above, the old above moves down
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_above[i_wr_addr] <= i_wr_sample;
            mem_two[i_wr_addr]   <= o_above;
        end
    end

    // forwarding when the read hits the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_above <= i_wr_sample;
        r_fwd_two   <= o_above;
    end

    assign o_above     = r_fwd_hit ? r_fwd_above : r_rd_above;
    assign o_two_above = r_fwd_hit ? r_fwd_two   : r_rd_two;

endmodule

### sv/sobg_grad.sv
// 3x3 window registers and the two sobel kernel sums per column pair
module sobg_grad #(
    parameter int SW = sobg_pkg::SAMPLE_W_DEF
) (
    input  logic                 i_clk,
    input  sobg_pkg::t_win_cmd   i_cmd,
    input  logic signed [SW-1:0] i_top,
    input  logic signed [SW-1:0] i_mid,
    input  logic signed [SW-1:0] i_bot,
    output logic signed [SW+2:0] o_gx_prev,
    output logic signed [SW+2:0] o_gy_prev,
    output logic signed [SW+2:0] o_gx_last,
    output logic signed [SW+2:0] o_gy_last
);

    localparam int GW = SW + 3;

    // r_win[col][pos], col 0 = left, pos 0 = top
    logic signed [SW-1:0] r_win [3][3];

    // weighted 1,2,1 sum of three samples
    function automatic logic signed [GW-1:0] ksum(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b,
        input logic signed [SW-1:0] c
    );
        logic signed [GW-1:0] ea;
        logic signed [GW-1:0] eb;
        logic signed [GW-1:0] ec;
        ea = GW'(a);
        eb = GW'(b);
        ec = GW'(c);
        return ea + (eb <<< 1) + ec;
    endfunction

    // column push, first column of a row replicates into all three
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (i_cmd.first) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= i_top;
                    r_win[k][1] <= i_mid;
                    r_win[k][2] <= i_bot;
                end
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2][0] <= i_top;
                r_win[2][1] <= i_mid;
                r_win[2][2] <= i_bot;
            end
        end
    end

    // centre at the middle column
    assign o_gx_prev = ksum(r_win[0][0], r_win[0][1], r_win[0][2])
                     - ksum(r_win[2][0], r_win[2][1], r_win[2][2]);
    assign o_gy_prev = ksum(r_win[0][0], r_win[1][0], r_win[2][0])
                     - ksum(r_win[0][2], r_win[1][2], r_win[2][2]);

    // centre at the right edge, right neighbour replicated
    assign o_gx_last = ksum(r_win[1][0], r_win[1][1], r_win[1][2])
                     - ksum(r_win[2][0], r_win[2][1], r_win[2][2]);
    assign o_gy_last = ksum(r_win[1][0], r_win[2][0], r_win[2][0])
                     - ksum(r_win[1][2], r_win[2][2], r_win[2][2]);

endmodule

### sv/sobg_resq.sv
// result queue taking up to two entries per cycle and giving one
module sobg_resq #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = sobg_pkg::RESQ_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push0,
    input  logic [DATA_W-1:0]        i_data0,
    input  logic                     i_push1,
    input  logic [DATA_W-1:0]        i_data1,
    output logic                     o_valid,
    output logic [DATA_W-1:0]        o_data,
    input  logic                     i_pop,
    output logic [$clog2(DEPTH):0]   o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     n_rd_ptr;
    logic [AW:0]       n_count;
    logic              pop_ok;
    logic [AW-1:0]     wr_ptr1;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wr_ptr1 = r_wr_ptr + AW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push0) + AW'(i_push1);
        n_rd_ptr = r_rd_ptr + AW'(pop_ok);
        n_count  = r_count + (AW+1)'(i_push0) + (AW+1)'(i_push1) - (AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### sv/sobel_gradient_3x3.sv
// streaming 3x3 sobel gradients with edge replication, top level
// Requests pass the line read and kernel stages, then results enter the result queue.
// Throughput: one request per cycle while o_in_ready is high; a last-column request
// gives two results if cols > 1, sent one per ready cycle from an 8-entry queue.
// Reset: frame size returns to 1024 x 1024 and the raster counters clear;
// line buffers are not cleared, every read hits an entry written in the same frame.
module sobel_gradient_3x3 #(
    parameter int MAX_COLS     = sobg_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_WIDTH = sobg_pkg::SAMPLE_W_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_WIDTH+2:0]        o_grad_x,
    output logic signed [SAMPLE_WIDTH+2:0]        o_grad_y,
    output logic [sobg_pkg::ROW_W-1:0]            o_out_row,
    output logic [$clog2(MAX_COLS)-1:0]           o_out_col,
    output logic                                  o_frame_end,
    output logic                                  o_run_last,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sobg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sobg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int GW    = SW + 3;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = sobg_pkg::ROW_W;
    localparam int QD    = sobg_pkg::RESQ_DEPTH;
    localparam int QCW   = $clog2(QD) + 1;
    localparam int DW    = 2 * GW + RW + CW + 2;
    localparam int RST_COLS = (sobg_pkg::FRAME_COLS_RST > MAX_COLS) ?
                              MAX_COLS : sobg_pkg::FRAME_COLS_RST;
    localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_COLS - 1);
    localparam logic [RW-1:0] RST_LAST_ROW = sobg_pkg::FRAME_ROWS_RST - RW'(1);

    // frame geometry and raster position
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;
    logic [CW-1:0] r_drain_col;
    logic [RW-1:0] n_last_row;
    logic [CW-1:0] n_last_col;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_in_col;
    logic [CW-1:0] n_drain_col;

    // accept stage
    logic                 in_acc;
    logic                 cfg_we;
    logic                 cfg_hit;
    logic                 samp_ok;
    logic                 drain_ok;
    logic [CW-1:0]        col_a;
    logic                 is_last_col;
    sobg_pkg::t_item_ctl  ctl_a;
    logic [RW-1:0]        row_a;
    logic [RW-1:0]        cfg_rows;
    logic [sobg_pkg::CFG_COLS_W-1:0] cfg_cols;
    logic [sobg_pkg::CFG_COLS_W-1:0] cfg_cols_m1;

    // line read stage
    logic                 r_b_valid;
    sobg_pkg::t_item_ctl  r_b_ctl;
    logic signed [SW-1:0] r_b_sample;
    logic [CW-1:0]        r_b_col;
    logic [RW-1:0]        r_b_row;
    logic signed [SW-1:0] line_m;
    logic signed [SW-1:0] line_t2;
    logic signed [SW-1:0] col_top;
    logic signed [SW-1:0] col_bot;
    sobg_pkg::t_win_cmd   win_cmd;

    // kernel stage
    logic                 r_c_valid;
    sobg_pkg::t_item_ctl  r_c_ctl;
    logic [CW-1:0]        r_c_col;
    logic [RW-1:0]        r_c_row;
    logic signed [GW-1:0] gx_prev;
    logic signed [GW-1:0] gy_prev;
    logic signed [GW-1:0] gx_last;
    logic signed [GW-1:0] gy_last;
    logic [DW-1:0]        res_prev;
    logic [DW-1:0]        res_last;
    logic                 both;
    logic                 push0;
    logic                 push1;
    logic [DW-1:0]        q_data;
    logic [QCW-1:0]       q_count;
    logic [QCW+1:0]       q_load;

    // request acceptance: room for two results per request in flight
    assign q_load     = (QCW+2)'(q_count) + (QCW+2)'({r_b_valid, 1'b0})
                      + (QCW+2)'({r_c_valid, 1'b0});
    assign o_in_ready = (q_load <= (QCW+2)'(QD - 2));
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_we     = i_cfg_valid && o_cfg_ready;

    // classify the request against the raster position
    always_comb begin
        samp_ok     = (i_func == sobg_pkg::FUNC_SAMPLE) && (r_in_row <= r_last_row);
        drain_ok    = (i_func == sobg_pkg::FUNC_DRAIN) && (r_in_row > r_last_row);
        col_a       = (i_func == sobg_pkg::FUNC_DRAIN) ? r_drain_col : r_in_col;
        is_last_col = (col_a == r_last_col);
        row_a       = drain_ok ? r_last_row : (r_in_row - RW'(1));
        ctl_a.line_wr    = samp_ok;
        ctl_a.win.push   = (samp_ok && (r_in_row != '0)) || drain_ok;
        ctl_a.win.first  = (col_a == '0);
        ctl_a.top_sel_m  = drain_ok ? (r_last_row == '0) : (r_in_row == RW'(1));
        ctl_a.bot_sel_m  = drain_ok;
        ctl_a.emit_prev  = ctl_a.win.push && (col_a != '0);
        ctl_a.emit_last  = ctl_a.win.push && is_last_col;
        ctl_a.frame_end  = drain_ok && is_last_col;
    end

    // configuration decode and raster counter update
    always_comb begin
        cfg_rows    = i_cfg_data[RW-1:0];
        cfg_cols    = i_cfg_data[sobg_pkg::CFG_COLS_W-1:0];
        cfg_cols_m1 = cfg_cols - sobg_pkg::CFG_COLS_W'(1);
        n_last_row  = r_last_row;
        n_last_col  = r_last_col;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_drain_col = r_drain_col;
        cfg_hit     = 1'b0;
        if (cfg_we) begin
            unique case (i_cfg_index)
                sobg_pkg::CFG_FRAME_ROWS: begin
                    cfg_hit    = 1'b1;
                    n_last_row = (cfg_rows == '0) ? '0 : (cfg_rows - RW'(1));
                end
                sobg_pkg::CFG_FRAME_COLS: begin
                    cfg_hit = 1'b1;
                    if (cfg_cols == '0) begin
                        n_last_col = '0;
                    end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
                        n_last_col = CW'(MAX_COLS - 1);
                    end else begin
                        n_last_col = CW'(cfg_cols_m1);
                    end
                end
                default: cfg_hit = 1'b0;
            endcase
        end
        if (cfg_hit) begin
            n_in_row    = '0;
            n_in_col    = '0;
            n_drain_col = '0;
        end else if (in_acc && samp_ok) begin
            if (is_last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end else if (in_acc && drain_ok) begin
            if (is_last_col) begin
                n_in_row    = '0;
                n_in_col    = '0;
                n_drain_col = '0;
            end else begin
                n_drain_col = r_drain_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row  <= RST_LAST_ROW;
            r_last_col  <= RST_LAST_COL;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_drain_col <= '0;
        end else begin
            r_last_row  <= n_last_row;
            r_last_col  <= n_last_col;
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_drain_col <= n_drain_col;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= in_acc && (samp_ok || drain_ok);
            r_c_valid <= r_b_valid && (r_b_ctl.emit_prev || r_b_ctl.emit_last);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_b_ctl    <= ctl_a;
        r_b_sample <= i_sample;
        r_b_col    <= col_a;
        r_b_row    <= row_a;
        r_c_ctl    <= r_b_ctl;
        r_c_col    <= r_b_col;
        r_c_row    <= r_b_row;
    end

    // line buffers, read at accept, written back in the following cycle
    sobg_lines #(
        .MAX_COLS (MAX_COLS),
        .SW       (SW)
    ) u_lines (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (col_a),
        .i_wr_en     (r_b_valid && r_b_ctl.line_wr),
        .i_wr_addr   (r_b_col),
        .i_wr_sample (r_b_sample),
        .o_above     (line_m),
        .o_two_above (line_t2)
    );

    // column entering the window, top and bottom replicated at frame edges
    always_comb begin
        col_top      = r_b_ctl.top_sel_m ? line_m : line_t2;
        col_bot      = r_b_ctl.bot_sel_m ? line_m : r_b_sample;
        win_cmd.push = r_b_valid && r_b_ctl.win.push;
        win_cmd.first = r_b_ctl.win.first;
    end

    sobg_grad #(
        .SW (SW)
    ) u_grad (
        .i_clk     (i_clk),
        .i_cmd     (win_cmd),
        .i_top     (col_top),
        .i_mid     (line_m),
        .i_bot     (col_bot),
        .o_gx_prev (gx_prev),
        .o_gy_prev (gy_prev),
        .o_gx_last (gx_last),
        .o_gy_last (gy_last)
    );

    // pack results, the edge result always last for its request
    always_comb begin
        both     = r_c_ctl.emit_prev && r_c_ctl.emit_last;
        push0    = r_c_valid;
        push1    = r_c_valid && both;
        res_prev = {gx_prev, gy_prev, r_c_row, r_c_col - CW'(1), 1'b0, !r_c_ctl.emit_last};
        res_last = {gx_last, gy_last, r_c_row, r_c_col, r_c_ctl.frame_end, 1'b1};
    end

    sobg_resq #(
        .DATA_W (DW),
        .DEPTH  (QD)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_data0 (r_c_ctl.emit_prev ? res_prev : res_last),
        .i_push1 (push1),
        .i_data1 (res_last),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .i_pop   (i_out_ready),
        .o_count (q_count)
    );

    assign {o_grad_x, o_grad_y, o_out_row, o_out_col, o_frame_end, o_run_last} = q_data;

    // the raster row never runs more than one past the last row
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (17'(r_in_row) <= 17'(r_last_row) + 17'd1))
        else $error("raster row beyond frame");

    // drain column only moves while the last row is being flushed
    a_drain_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain_col != '0) |-> (r_in_row > r_last_row))
        else $error("drain column advanced outside drain");

    // the frame end result closes its request
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_run_last)
        else $error("frame end result not last of its request");

    // no result queue overflow
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(q_count) <= QD))
        else $error("result queue overflow");

endmodule

### verif/tb.sv
// self-checking testbench for the streaming 3x3 sobel gradient block
`timescale 1ns / 100ps

module tb;
    import sobg_pkg::*;

    localparam int SW  = SAMPLE_W_DEF;
    localparam int GW  = SAMPLE_W_DEF + 3;
    localparam int CW  = $clog2(MAX_COLS_DEF);
    localparam int RW  = ROW_W;
    localparam int MXC = MAX_COLS_DEF;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int QUIET_CYC  = 10;
    localparam int TAIL_CYC   = 20;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_AT    = 2500;
    localparam int HOLD_LEN   = 300;
    localparam int CALM_LO    = 3000;
    localparam int CALM_HI    = 3400;
    localparam int IDLE_PCT   = 22;
    localparam int RAND_ITEMS = 2000;
    localparam int MAX_SHOWN  = 10;

    // one gradient result
    typedef struct {
        logic signed [GW-1:0] gx;
        logic signed [GW-1:0] gy;
        logic [RW-1:0]        row;
        logic [CW-1:0]        col;
        logic                 fend;
        logic                 rlast;
    } grad_t;

    // one queued request: pixel/drain or register write
    typedef struct {
        bit                    is_cfg;
        logic                  func;
        logic signed [SW-1:0]  sample;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } stim_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_func      = FUNC_SAMPLE;
    logic signed [SW-1:0]  i_sample    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic signed [GW-1:0]  o_grad_x;
    logic signed [GW-1:0]  o_grad_y;
    logic [RW-1:0]         o_out_row;
    logic [CW-1:0]         o_out_col;
    logic                  o_frame_end;
    logic                  o_run_last;
    logic                  o_cfg_ready;

    sobel_gradient_3x3 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // gradient predictor state
    // ------------------------------------------------------------------
    logic [RW-1:0]         cfg_rows = FRAME_ROWS_RST;
    logic [CFG_COLS_W-1:0] cfg_cols = CFG_COLS_W'(FRAME_COLS_RST);
    bit signed [SW-1:0]    pix_up   [MXC];
    bit signed [SW-1:0]    pix_up2  [MXC];
    bit signed [SW-1:0]    kern_win [9];
    logic [RW-1:0]         rast_row  = '0;
    logic [CW-1:0]         rast_col  = '0;
    logic [CFG_COLS_W-1:0] flush_col = '0;

    grad_t grad_q[$];
    stim_t pending[$];

    int err_cnt     = 0;
    int checked     = 0;
    int frames_done = 0;
    int cfg_done    = 0;
    int req_done    = 0;
    int useful_reqs = 0;
    int noise_reqs  = 0;

    function automatic int rows_eff();
        return (cfg_rows == 0) ? 1 : int'(cfg_rows);
    endfunction

    function automatic int cols_eff();
        if (cfg_cols == 0) return 1;
        if (int'(cfg_cols) > MXC) return MXC;
        return int'(cfg_cols);
    endfunction

    // slide the 3x3 window by one column, or fill it on column zero
    task automatic shift_column(input bit signed [SW-1:0] t, m, b, input bit first);
        int k;
        if (first) begin
            for (k = 0; k < 3; k++) begin
                kern_win[k*3]   = t;
                kern_win[k*3+1] = m;
                kern_win[k*3+2] = b;
            end
        end else begin
            for (k = 0; k < 6; k++) kern_win[k] = kern_win[k+3];
            kern_win[6] = t;
            kern_win[7] = m;
            kern_win[8] = b;
        end
    endtask

    // sobel sums from chosen left, center and right window columns
    function automatic grad_t make_grad(input int lc, cc, rc, row, col);
        grad_t r;
        int    gx, gy;
        gx = (int'(kern_win[lc*3]) + 2 * int'(kern_win[lc*3+1]) + int'(kern_win[lc*3+2]))
           - (int'(kern_win[rc*3]) + 2 * int'(kern_win[rc*3+1]) + int'(kern_win[rc*3+2]));
        gy = (int'(kern_win[lc*3]) + 2 * int'(kern_win[cc*3]) + int'(kern_win[rc*3]))
           - (int'(kern_win[lc*3+2]) + 2 * int'(kern_win[cc*3+2]) + int'(kern_win[rc*3+2]));
        r.gx    = gx[GW-1:0];
        r.gy    = gy[GW-1:0];
        r.row   = row[RW-1:0];
        r.col   = col[CW-1:0];
        r.fend  = 1'b0;
        r.rlast = 1'b0;
        return r;
    endfunction

    // a completed column gives the result left of it, plus its own at the row end
    task automatic finish_column(input bit signed [SW-1:0] t, m, b,
                                 input int col, cols, row, input bit last_row);
        grad_t r0, r1;
        bit    have0;
        shift_column(t, m, b, col == 0);
        have0 = 1'b0;
        if (col >= 1) begin
            r0    = make_grad(0, 1, 2, row, col - 1);
            have0 = 1'b1;
        end
        if (col == cols - 1) begin
            r1       = make_grad(1, 2, 2, row, col);
            r1.fend  = last_row;
            r1.rlast = 1'b1;
            if (have0) grad_q.push_back(r0);
            grad_q.push_back(r1);
        end else if (have0) begin
            r0.rlast = 1'b1;
            grad_q.push_back(r0);
        end
    endtask

    // expected results of one accepted request
    task automatic predict_request(input logic func, input logic signed [SW-1:0] smp);
        int                 rows, cols, c;
        bit signed [SW-1:0] m, t;
        rows = rows_eff();
        cols = cols_eff();
        if (func == FUNC_SAMPLE) begin
            c = int'(rast_col);
            // samples past the frame's last pixel are dropped
            if (int'(rast_row) >= rows || c >= cols) return;
            m = pix_up[c];
            if (rast_row >= 1) begin
                t = (rast_row == 1) ? m : pix_up2[c];
                finish_column(t, m, smp, c, cols, int'(rast_row) - 1, 1'b0);
            end
            pix_up2[c] = m;
            pix_up[c]  = smp;
            if (c == cols - 1) begin
                rast_col = '0;
                rast_row = rast_row + 1'b1;
            end else begin
                rast_col = CW'(c + 1);
            end
        end else begin
            c = int'(flush_col);
            // drain before the frame is complete is dropped
            if (int'(rast_row) < rows || c >= cols) return;
            m = pix_up[c];
            t = (rows == 1) ? m : pix_up2[c];
            finish_column(t, m, m, c, cols, rows - 1, 1'b1);
            if (c == cols - 1) begin
                rast_row  = '0;
                rast_col  = '0;
                flush_col = '0;
                frames_done++;
            end else begin
                flush_col = CFG_COLS_W'(c + 1);
            end
        end
    endtask

    // register write; a real register restarts the frame
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_FRAME_ROWS) cfg_rows = d;
        else if (idx == CFG_FRAME_COLS) cfg_cols = d[CFG_COLS_W-1:0];
        else return;
        rast_row  = '0;
        rast_col  = '0;
        flush_col = '0;
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic add_req(input logic func, input logic signed [SW-1:0] smp, input bit noise);
        stim_t s;
        s.is_cfg = 1'b0;
        s.func   = func;
        s.sample = smp;
        s.idx    = '0;
        s.data   = '0;
        pending.push_back(s);
        if (noise) noise_reqs++;
        else useful_reqs++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        stim_t s;
        s.is_cfg = 1'b1;
        s.func   = FUNC_SAMPLE;
        s.sample = '0;
        s.idx    = idx;
        s.data   = d;
        pending.push_back(s);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        int s;
        s = $urandom_range(0, 99);
        if (s < 8) return {1'b0, {(SW-1){1'b1}}};
        if (s < 16) return {1'b1, {(SW-1){1'b0}}};
        if (s < 20) return '0;
        return SW'($urandom());
    endfunction

    // one frame in raster order, then its drain, with stray noise; may be cut short
    task automatic gen_frame(input int rows, cols, output bit cut_short);
        int total, cut, idx;
        total     = rows * cols + cols;
        cut_short = ($urandom_range(0, 99) < 6);
        cut       = cut_short ? $urandom_range(0, total - 1) : total;
        for (idx = 0; idx < cut; idx++) begin
            if (idx < rows * cols) begin
                if ($urandom_range(0, 99) < 3) add_req(FUNC_DRAIN, SW'($urandom()), 1'b1);
                add_req(FUNC_SAMPLE, pick_sample(), 1'b0);
            end else begin
                if ($urandom_range(0, 99) < 4) add_req(FUNC_SAMPLE, pick_sample(), 1'b1);
                add_req(FUNC_DRAIN, SW'($urandom()), 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: pixel/drain channel and register channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        bit    in_fire, cfg_fire, out_fire, nxt_in, nxt_cfg, calm;
        int    quiet_cyc;
        stim_t it;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet_cyc   = 0;
        end else begin
            in_fire  = i_in_valid && o_in_ready;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            out_fire = o_out_valid && i_out_ready;
            if (in_fire) begin
                predict_request(i_func, i_sample);
                req_done++;
            end
            if (cfg_fire) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                cfg_done++;
            end
            quiet_cyc = (in_fire || cfg_fire || out_fire) ? 0 : quiet_cyc + 1;
            nxt_in  = i_in_valid && !in_fire;
            nxt_cfg = i_cfg_valid && !cfg_fire;
            calm    = (req_done >= CALM_LO) && (req_done < CALM_HI);
            if (!nxt_in && !nxt_cfg && pending.size() > 0) begin
                if (pending[0].is_cfg) begin
                    // register writes only once the block has gone quiet
                    if (quiet_cyc >= QUIET_CYC && grad_q.size() == 0) begin
                        it = pending.pop_front();
                        nxt_cfg = 1'b1;
                        i_cfg_index <= it.idx;
                        i_cfg_data  <= it.data;
                    end
                end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                    it = pending.pop_front();
                    nxt_in = 1'b1;
                    i_func   <= it.func;
                    i_sample <= it.sample;
                end
            end
            i_in_valid  <= nxt_in;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : grad_monitor
        bit    rdy, hold_done;
        int    in_seen, hold_left;
        grad_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            in_seen   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            // compare each accepted result with the oldest expectation
            if (o_out_valid && i_out_ready) begin
                if (grad_q.size() == 0) begin
                    if (err_cnt < MAX_SHOWN)
                        $display("unexpected result gx=%0d gy=%0d row=%0d col=%0d end=%0b last=%0b",
                                 o_grad_x, o_grad_y, o_out_row, o_out_col, o_frame_end,
                                 o_run_last);
                    err_cnt++;
                end else begin
                    want = grad_q.pop_front();
                    if (o_grad_x !== want.gx || o_grad_y !== want.gy ||
                        o_out_row !== want.row || o_out_col !== want.col ||
                        o_frame_end !== want.fend || o_run_last !== want.rlast) begin
                        if (err_cnt < MAX_SHOWN) begin
                            $display("mismatch on result %0d: exp gx=%0d gy=%0d row=%0d col=%0d end=%0b last=%0b",
                                     checked, want.gx, want.gy, want.row, want.col,
                                     want.fend, want.rlast);
                            $display("    got gx=%0d gy=%0d row=%0d col=%0d end=%0b last=%0b",
                                     o_grad_x, o_grad_y, o_out_row, o_out_col,
                                     o_frame_end, o_run_last);
                        end
                        err_cnt++;
                    end
                    checked++;
                end
            end
            // ready pattern: one long hold-off, one calm stretch, random otherwise
            if (i_in_valid && o_in_ready) in_seen++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && in_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                rdy = 1'b0;
            end else if (in_seen >= CALM_LO && in_seen < CALM_HI) begin
                rdy = 1'b1;
            end else begin
                rdy = ($urandom_range(0, 99) >= IDLE_PCT);
            end
            i_out_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // watchdog on any request moving
    // ------------------------------------------------------------------
    int stall_cyc = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cyc <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            stall_cyc <= 0;
        end else if (stall_cyc >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     stall_cyc, grad_q.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence and end of run
    // ------------------------------------------------------------------
    initial begin : main_seq
        int                    p, nfr, fr, er, ec, npart, sel;
        bit                    cut, wr_rows, wr_cols, partial;
        logic [CFG_DATA_W-1:0] rv, cv;

        // reset geometry: a few samples then an early drain, all without results
        add_req(FUNC_SAMPLE, 16'sh7FFF, 1'b0);
        add_req(FUNC_SAMPLE, 16'sh8000, 1'b0);
        add_req(FUNC_SAMPLE, '0, 1'b0);
        add_req(FUNC_DRAIN, 16'shFFFF, 1'b1);

        // zero sizes act as a 1x1 frame
        add_cfg(CFG_FRAME_ROWS, 16'h0000);
        add_cfg(CFG_FRAME_COLS, 16'h0000);
        add_req(FUNC_DRAIN, '0, 1'b1);
        add_req(FUNC_SAMPLE, 16'sh8000, 1'b0);
        add_req(FUNC_SAMPLE, 16'sh7FFF, 1'b1);
        add_req(FUNC_DRAIN, 16'sh5A5A, 1'b0);
        add_req(FUNC_SAMPLE, 16'sh7FFF, 1'b0);
        add_req(FUNC_DRAIN, '0, 1'b0);

        // writes to unused indexes leave the frame alone
        add_cfg(CFG_SPARE_A, 16'h0003);
        add_cfg(CFG_SPARE_B, 16'hFFFF);

        // 3x3 frame with full-scale left and right columns for peak gradients
        add_cfg(CFG_FRAME_ROWS, 16'd3);
        add_cfg(CFG_FRAME_COLS, 16'd3);
        for (p = 0; p < 9; p++) begin
            if (p % 3 == 0) add_req(FUNC_SAMPLE, 16'sh7FFF, 1'b0);
            else if (p % 3 == 1) add_req(FUNC_SAMPLE, 16'shFFFF, 1'b0);
            else add_req(FUNC_SAMPLE, 16'sh8000, 1'b0);
        end
        for (p = 0; p < 3; p++) add_req(FUNC_DRAIN, '0, 1'b0);

        // widest row: column count beyond the buffer clamps, single-row frame
        add_cfg(CFG_FRAME_ROWS, 16'h0001);
        add_cfg(CFG_FRAME_COLS, 16'hFFFF);
        for (p = 0; p < MXC; p++) add_req(FUNC_SAMPLE, pick_sample(), 1'b0);
        for (p = 0; p < MXC; p++) add_req(FUNC_DRAIN, SW'($urandom()), 1'b0);
        useful_reqs = 0;

        // random frame geometries, mostly small and complete
        rv = 16'h0001;
        cv = 16'hFFFF;
        while (useful_reqs < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) rv = 16'h0000;
            else if (sel < 8) rv = 16'hFFFF;
            else if (sel < 11) rv = CFG_DATA_W'($urandom());
            else rv = CFG_DATA_W'($urandom_range(1, 6));
            sel = $urandom_range(0, 99);
            if (sel < 4) cv[CFG_COLS_W-1:0] = '0;
            else if (sel < 10) cv[CFG_COLS_W-1:0] = 1;
            else if (sel < 13) cv[CFG_COLS_W-1:0] = MXC;
            else if (sel < 80) cv[CFG_COLS_W-1:0] = CFG_COLS_W'($urandom_range(2, 8));
            else cv[CFG_COLS_W-1:0] = CFG_COLS_W'($urandom_range(9, 40));
            cv[CFG_DATA_W-1:CFG_COLS_W] = $urandom();
            wr_rows = ($urandom_range(0, 4) != 0);
            wr_cols = ($urandom_range(0, 4) != 0) || !wr_rows;
            if ($urandom_range(0, 1)) begin
                if (wr_rows) add_cfg(CFG_FRAME_ROWS, rv);
                if (wr_cols) add_cfg(CFG_FRAME_COLS, cv);
            end else begin
                if (wr_cols) add_cfg(CFG_FRAME_COLS, cv);
                if (wr_rows) add_cfg(CFG_FRAME_ROWS, rv);
            end
            // geometry as the block will see it after the writes
            if (!wr_rows) rv = pending_rows_value();
            if (!wr_cols) cv = pending_cols_value();
            note_geometry(rv, cv);
            er = (rv == 0) ? 1 : int'(rv);
            ec = (cv[CFG_COLS_W-1:0] == 0) ? 1 :
                 (int'(cv[CFG_COLS_W-1:0]) > MXC) ? MXC : int'(cv[CFG_COLS_W-1:0]);
            partial = (er > 8) || (ec > 64);
            if (partial) begin
                // huge frames: only the first rows, then a restart
                npart = $urandom_range(1, (ec > 64) ? 80 : 5 * ec);
                for (p = 0; p < npart; p++) begin
                    if ($urandom_range(0, 99) < 3) add_req(FUNC_DRAIN, SW'($urandom()), 1'b1);
                    add_req(FUNC_SAMPLE, pick_sample(), 1'b0);
                end
            end else begin
                nfr = (er * ec <= 64) ? $urandom_range(1, 3) : 1;
                for (fr = 0; fr < nfr; fr++) begin
                    gen_frame(er, ec, cut);
                    if (cut) break;
                end
            end
        end

        // reset, then let the driver work through the list
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
            #1;
        end while (pending.size() != 0 || i_in_valid || i_cfg_valid || grad_q.size() != 0);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("run covered %0d requests (%0d stray) and %0d register writes",
                 req_done, noise_reqs, cfg_done);
        $display("checked %0d gradient results over %0d completed frames, %0d errors",
                 checked, frames_done, err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // geometry last written, as tracked while the list is built
    logic [CFG_DATA_W-1:0] gen_rows_last = 16'h0001;
    logic [CFG_DATA_W-1:0] gen_cols_last = 16'hFFFF;

    function automatic logic [CFG_DATA_W-1:0] pending_rows_value();
        return gen_rows_last;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pending_cols_value();
        return gen_cols_last;
    endfunction

    task automatic note_geometry(input logic [CFG_DATA_W-1:0] r, c);
        gen_rows_last = r;
        gen_cols_last = c;
    endtask

endmodule
